@@ sv/assert_macros.svh @@
// Assertion macros shared by the collision core RTL.
// No dependencies; the design takes this header by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

@@ sv/ppc_pkg.sv @@
// Package for the particle pair collision core: fixed-point widths, payload types
// and the saturation and bounce helpers. No dependencies.
`timescale 1ns / 1ps
package ppc_pkg;
	localparam int FRAC_BITS = 16;
	localparam int WORD_W    = 32;
	localparam int N_FIELDS  = 12;
	localparam int DATA_W    = WORD_W * N_FIELDS;
	localparam int CFG_W     = 17;
	localparam int CFG_RESET = 32768;

	localparam int ONE     = 1 << FRAC_BITS;
	localparam int MAG_W   = FRAC_BITS;
	localparam int SQ_W    = 2 * FRAC_BITS;
	localparam int SUM_W   = 2 * FRAC_BITS + 2;
	localparam int REM_W   = FRAC_BITS + 2;
	localparam int QT_W    = FRAC_BITS + 1;
	localparam int NRM_W   = FRAC_BITS + 2;
	localparam int DEPTH_W = FRAC_BITS;
	localparam int PP_W    = QT_W + DEPTH_W;
	localparam int DP_W    = WORD_W + 1 + NRM_W;
	localparam int DSUM_W  = DP_W + 2;
	localparam int DOT_W   = DSUM_W - FRAC_BITS;
	localparam int FAC_W   = FRAC_BITS + 2;
	localparam int EP_W    = DOT_W + FAC_W + 1;
	localparam int EX_W    = EP_W - (FRAC_BITS + 1);
	localparam int TP_W    = EX_W + NRM_W;
	localparam int T_W     = TP_W - FRAC_BITS;
	localparam int WIDE_W  = T_W + 2;

	typedef logic [2:0][WORD_W-1:0] vec_t;

	typedef struct packed {
		vec_t a_pos;
		vec_t a_step;
		vec_t b_pos;
		vec_t b_step;
	} pair_t;

	typedef struct packed {
		pair_t                 pl;
		logic [2:0][MAG_W-1:0] dmag;
		logic [2:0]            dneg;
		logic                  contact;
		logic                  zero;
	} carry_t;

	function automatic logic [WORD_W-1:0] sat_w(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = WIDE_W'({1'b0, {(WORD_W-1){1'b1}}});
		lo = ~hi;
		if (v > hi)
			return hi[WORD_W-1:0];
		else if (v < lo)
			return lo[WORD_W-1:0];
		return v[WORD_W-1:0];
	endfunction

	// ONE + restitution rescaled from Q0.16 to the working fraction
	function automatic logic [FAC_W-1:0] bounce_factor(input logic [CFG_W-1:0] r);
		logic [FAC_W+CFG_W-1:0] scaled;
		if (FRAC_BITS >= 16)
			scaled = (FAC_W+CFG_W)'(r) << (FRAC_BITS >= 16 ? FRAC_BITS - 16 : 0);
		else
			scaled = (FAC_W+CFG_W)'(r) >> (FRAC_BITS < 16 ? 16 - FRAC_BITS : 0);
		return FAC_W'(ONE) + scaled[FAC_W-1:0];
	endfunction
endpackage

@@ sv/particle_pair_collision_core.sv @@
// Top level of the particle pair collision core: a fully pipelined contact test,
// square root, normal division, push and velocity exchange. Depends on ppc_pkg
// and assert_macros.svh.
//
// Usage:
//   s_axis_* carries one particle pair per transaction, m_axis_* the updated pair.
//   Both use the 384-bit word layout below, 32-bit signed Q15.16 fields.
//   cfg_wr_en / cfg_wr_data set the restitution factor (Q0.16, 17 bits);
//   write it only while the pipeline is empty.
// Order of work from input transaction to m_axis_tvalid, on Q15.16 fields:
//   difference, squares and squared distance, the square root (FRAC_BITS
//   result bits), the division (FRAC_BITS + 1 quotient bits), push, exchange.
// Throughput: one pair per cycle unless stalled; every stage holds an independent pair.
// Reset: all valid bits clear, restitution returns to 0.5.
// Stall: while m_axis_tvalid is high and m_axis_tready low, the whole pipeline
//   holds, bubbles included, and s_axis_tready drops; otherwise every stage
//   advances. Nothing is lost or repeated.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module particle_pair_collision_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [ppc_pkg::CFG_W-1:0]  cfg_wr_data,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// a_pos_x,y,z, a_step_x,y,z, b_pos_x,y,z, b_step_x,y,z; 32 bits each, lowest first
	input  logic [ppc_pkg::DATA_W-1:0] s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// new_a_pos_x,y,z, new_a_step_x,y,z, new_b_pos_x,y,z, new_b_step_x,y,z
	output logic [ppc_pkg::DATA_W-1:0] m_axis_tdata
);
	import ppc_pkg::*;

	localparam int F = FRAC_BITS;

	logic             adv;
	logic [CFG_W-1:0] restitution_q;
	logic [FAC_W-1:0] fac;

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			restitution_q <= CFG_W'(CFG_RESET);
		else if (cfg_wr_en)
			restitution_q <= cfg_wr_data;
	end
	assign fac = bounce_factor(restitution_q);

	// Advance every stage together unless the output register is blocked
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// ---------------- Stage 1: unpack, separation, near test
	pair_t                 pl_in;
	logic [2:0][MAG_W-1:0] dmag_in;
	logic [2:0]            dneg_in;
	logic                  near_in;

	always_comb begin
		logic signed [WORD_W:0] d;
		near_in = 1'b1;
		for (int k = 0; k < 3; k++) begin
			pl_in.a_pos[k]  = s_axis_tdata[WORD_W*k +: WORD_W];
			pl_in.a_step[k] = s_axis_tdata[WORD_W*(3+k) +: WORD_W];
			pl_in.b_pos[k]  = s_axis_tdata[WORD_W*(6+k) +: WORD_W];
			pl_in.b_step[k] = s_axis_tdata[WORD_W*(9+k) +: WORD_W];
			d = (WORD_W+1)'($signed(pl_in.a_pos[k])) - (WORD_W+1)'($signed(pl_in.b_pos[k]));
			if (d >= $signed((WORD_W+1)'(ONE)) || d <= -$signed((WORD_W+1)'(ONE)))
				near_in = 1'b0;
			dneg_in[k] = d[WORD_W];
			dmag_in[k] = d[WORD_W] ? MAG_W'(-d) : MAG_W'(d);
		end
	end

	logic   v_s1;
	carry_t c_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= s_axis_tvalid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1.pl      <= pl_in;
			c_s1.dmag    <= dmag_in;
			c_s1.dneg    <= dneg_in;
			c_s1.contact <= near_in;
			c_s1.zero    <= 1'b0;
		end
	end

	// ---------------- Stage 2: squares of the separation
	logic                 v_s2;
	carry_t               c_s2;
	logic [2:0][SQ_W-1:0] sq_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (adv)
			v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			c_s2 <= c_s1;
			for (int k = 0; k < 3; k++)
				sq_s2[k] <= SQ_W'(c_s1.dmag[k]) * SQ_W'(c_s1.dmag[k]);
		end
	end

	// ---------------- Stage 3: squared distance and contact decision
	logic [SUM_W-1:0] ssum;
	assign ssum = SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]);

	logic             rt_v_s    [0:F];
	carry_t           rt_c_s    [0:F];
	logic [SQ_W-1:0]  rt_x_s    [0:F];
	logic [REM_W-1:0] rt_rem_s  [0:F];
	logic [F-1:0]     rt_root_s [0:F];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rt_v_s[0] <= 1'b0;
		else if (adv)
			rt_v_s[0] <= v_s2;
	end
	always_ff @(posedge clk) begin
		carry_t c3;
		c3         = c_s2;
		c3.contact = c_s2.contact && (ssum[SUM_W-1:SQ_W] == '0);
		c3.zero    = (ssum == '0);
		if (adv) begin
			rt_c_s[0]    <= c3;
			rt_x_s[0]    <= ssum[SQ_W-1:0];
			rt_rem_s[0]  <= '0;
			rt_root_s[0] <= '0;
		end
	end

	// ---------------- Square root: one result bit per stage
	for (genvar i = 0; i < F; i++) begin : g_sqrt
		logic [REM_W-1:0] remn;
		logic [REM_W-1:0] trial;
		logic             ge;
		assign remn  = {rt_rem_s[i][REM_W-3:0], rt_x_s[i][2*(F-1-i) +: 2]};
		assign trial = {rt_root_s[i], 2'b01};
		assign ge    = remn >= trial;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				rt_v_s[i+1] <= 1'b0;
			else if (adv)
				rt_v_s[i+1] <= rt_v_s[i];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rt_c_s[i+1]    <= rt_c_s[i];
				rt_x_s[i+1]    <= rt_x_s[i];
				rt_rem_s[i+1]  <= ge ? remn - trial : remn;
				rt_root_s[i+1] <= {rt_root_s[i][F-2:0], ge};
			end
		end
	end

	// ---------------- Normal division: one quotient bit per stage, three lanes
	logic                 dv_v_s    [1:F+1];
	carry_t               dv_c_s    [1:F+1];
	logic [F-1:0]         dv_dist_s [1:F+1];
	logic [2:0][F-1:0]    dv_rem_s  [1:F+1];
	logic [2:0][QT_W-1:0] dv_q_s    [1:F+1];

	for (genvar j = 0; j <= F; j++) begin : g_div
		logic                 v_in;
		carry_t               c_in;
		logic [F-1:0]         dist_in;
		logic [2:0][F-1:0]    rem_in;
		logic [2:0][QT_W-1:0] q_in;
		logic [2:0]           bit_in;
		if (j == 0) begin : g_first
			assign v_in    = rt_v_s[F];
			assign c_in    = rt_c_s[F];
			assign dist_in = rt_root_s[F];
			for (genvar k = 0; k < 3; k++) begin : g_lane
				assign rem_in[k] = {1'b0, rt_c_s[F].dmag[k][MAG_W-1:1]};
				assign q_in[k]   = '0;
				assign bit_in[k] = rt_c_s[F].dmag[k][0];
			end
		end else begin : g_next
			assign v_in    = dv_v_s[j];
			assign c_in    = dv_c_s[j];
			assign dist_in = dv_dist_s[j];
			assign rem_in  = dv_rem_s[j];
			assign q_in    = dv_q_s[j];
			assign bit_in  = '0;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_v_s[j+1] <= 1'b0;
			else if (adv)
				dv_v_s[j+1] <= v_in;
		end
		always_ff @(posedge clk) begin
			logic [F:0] remn;
			if (adv) begin
				dv_c_s[j+1]    <= c_in;
				dv_dist_s[j+1] <= dist_in;
				for (int k = 0; k < 3; k++) begin
					remn = {rem_in[k], bit_in[k]};
					if (remn >= {1'b0, dist_in}) begin
						dv_rem_s[j+1][k] <= F'(remn - {1'b0, dist_in});
						dv_q_s[j+1][k]   <= {q_in[k][QT_W-2:0], 1'b1};
					end else begin
						dv_rem_s[j+1][k] <= F'(remn);
						dv_q_s[j+1][k]   <= {q_in[k][QT_W-2:0], 1'b0};
					end
				end
			end
		end
	end

	// ---------------- Stage 4: signed normal, overlap depth, push product
	localparam int L = F + 1;
	logic [DEPTH_W-1:0] depth;
	assign depth = DEPTH_W'((QT_W'(ONE) - {1'b0, dv_dist_s[L]}) >> 1);

	logic                 v_s4;
	carry_t               c_s4;
	logic [2:0][QT_W-1:0] nmag_s4;
	logic [2:0]           nneg_s4;
	logic [2:0][PP_W-1:0] pp_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (adv)
			v_s4 <= dv_v_s[L];
	end
	always_ff @(posedge clk) begin
		logic [QT_W-1:0] nm;
		if (adv) begin
			c_s4 <= dv_c_s[L];
			for (int k = 0; k < 3; k++) begin
				// Coincident pair: normal fixed at +x
				if (dv_c_s[L].zero)
					nm = (k == 0) ? QT_W'(ONE) : '0;
				else
					nm = dv_q_s[L][k];
				nmag_s4[k] <= nm;
				nneg_s4[k] <= dv_c_s[L].zero ? 1'b0 : dv_c_s[L].dneg[k];
				pp_s4[k]   <= PP_W'(nm) * PP_W'(depth);
			end
		end
	end

	// ---------------- Stage 5: apply the push, saturating
	logic                         v_s5;
	pair_t                        pl_s5;
	logic                         contact_s5;
	logic signed [2:0][NRM_W-1:0] n_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else if (adv)
			v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		logic signed [NRM_W-1:0] push;
		logic [PP_W-F-1:0]       pm;
		if (adv) begin
			contact_s5 <= c_s4.contact;
			for (int k = 0; k < 3; k++) begin
				pm = pp_s4[k][PP_W-1:F];
				if (!c_s4.contact)
					push = '0;
				else if (nneg_s4[k])
					push = -$signed(NRM_W'(pm));
				else
					push = $signed(NRM_W'(pm));
				n_s5[k] <= nneg_s4[k] ? -$signed(NRM_W'(nmag_s4[k])) :
					$signed(NRM_W'(nmag_s4[k]));
				pl_s5.a_pos[k]  <= sat_w(WIDE_W'($signed(c_s4.pl.a_pos[k])) + WIDE_W'(push));
				pl_s5.a_step[k] <= sat_w(WIDE_W'($signed(c_s4.pl.a_step[k])) + WIDE_W'(push));
				pl_s5.b_pos[k]  <= sat_w(WIDE_W'($signed(c_s4.pl.b_pos[k])) - WIDE_W'(push));
				pl_s5.b_step[k] <= sat_w(WIDE_W'($signed(c_s4.pl.b_step[k])) - WIDE_W'(push));
			end
		end
	end

	// ---------------- Stage 6: relative step times normal, per lane
	logic                         v_s6;
	pair_t                        pl_s6;
	logic                         contact_s6;
	logic signed [2:0][NRM_W-1:0] n_s6;
	logic signed [2:0][DP_W-1:0]  dp_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (adv)
			v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		logic signed [WORD_W:0] diff;
		if (adv) begin
			pl_s6      <= pl_s5;
			contact_s6 <= contact_s5;
			n_s6       <= n_s5;
			for (int k = 0; k < 3; k++) begin
				diff = (WORD_W+1)'($signed(pl_s5.a_step[k])) -
					(WORD_W+1)'($signed(pl_s5.b_step[k]));
				dp_s6[k] <= DP_W'(diff) * DP_W'($signed(n_s5[k]));
			end
		end
	end

	// ---------------- Stage 7: dot product, truncated toward zero
	logic signed [DSUM_W-1:0] dsum;
	logic signed [DSUM_W-1:0] dadj;
	assign dsum = DSUM_W'($signed(dp_s6[0])) + DSUM_W'($signed(dp_s6[1])) +
		DSUM_W'($signed(dp_s6[2]));
	assign dadj = dsum + (dsum[DSUM_W-1] ? DSUM_W'(ONE - 1) : DSUM_W'(0));

	logic                         v_s7;
	pair_t                        pl_s7;
	logic                         contact_s7;
	logic signed [2:0][NRM_W-1:0] n_s7;
	logic signed [DOT_W-1:0]      dot_s7;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s7 <= 1'b0;
		else if (adv)
			v_s7 <= v_s6;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			pl_s7      <= pl_s6;
			contact_s7 <= contact_s6;
			n_s7       <= n_s6;
			dot_s7     <= DOT_W'(dadj >>> F);
		end
	end

	// ---------------- Stage 8: scale by (1 + restitution)
	logic                         v_s8;
	pair_t                        pl_s8;
	logic                         contact_s8;
	logic signed [2:0][NRM_W-1:0] n_s8;
	logic signed [EP_W-1:0]       ep_s8;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s8 <= 1'b0;
		else if (adv)
			v_s8 <= v_s7;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			pl_s8      <= pl_s7;
			contact_s8 <= contact_s7;
			n_s8       <= n_s7;
			ep_s8      <= EP_W'(dot_s7) * EP_W'($signed({1'b0, fac}));
		end
	end

	// ---------------- Stage 9: exchange amount and its threshold
	logic signed [EP_W-1:0] eadj;
	logic signed [EX_W-1:0] exch;
	assign eadj = ep_s8 + (ep_s8[EP_W-1] ? EP_W'((2 * ONE) - 1) : EP_W'(0));
	assign exch = EX_W'(eadj >>> (F + 1));

	logic                         v_s9;
	pair_t                        pl_s9;
	logic                         ex_s9;
	logic signed [2:0][NRM_W-1:0] n_s9;
	logic signed [EX_W-1:0]       exch_s9;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s9 <= 1'b0;
		else if (adv)
			v_s9 <= v_s8;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			pl_s9   <= pl_s8;
			n_s9    <= n_s8;
			exch_s9 <= exch;
			ex_s9   <= contact_s8 && (exch > $signed(EX_W'(ONE)));
		end
	end

	// ---------------- Stage 10: exchange vector products
	logic                        v_s10;
	pair_t                       pl_s10;
	logic                        ex_s10;
	logic signed [2:0][TP_W-1:0] tp_s10;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s10 <= 1'b0;
		else if (adv)
			v_s10 <= v_s9;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			pl_s10 <= pl_s9;
			ex_s10 <= ex_s9;
			for (int k = 0; k < 3; k++)
				tp_s10[k] <= TP_W'($signed(n_s9[k])) * TP_W'(exch_s9);
		end
	end

	// ---------------- Stage 11: apply the exchange into the output register
	logic  v_s11;
	pair_t pl_s11;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s11 <= 1'b0;
		else if (adv)
			v_s11 <= v_s10;
	end
	always_ff @(posedge clk) begin
		logic signed [TP_W-1:0] tadj;
		logic signed [T_W-1:0]  t;
		if (adv) begin
			pl_s11.a_pos <= pl_s10.a_pos;
			pl_s11.b_pos <= pl_s10.b_pos;
			for (int k = 0; k < 3; k++) begin
				tadj = tp_s10[k] + (tp_s10[k][TP_W-1] ? TP_W'(ONE - 1) : TP_W'(0));
				t    = ex_s10 ? T_W'(tadj >>> F) : T_W'(0);
				pl_s11.a_step[k] <= sat_w(WIDE_W'($signed(pl_s10.a_step[k])) + WIDE_W'(t));
				pl_s11.b_step[k] <= sat_w(WIDE_W'($signed(pl_s10.b_step[k])) - WIDE_W'(t));
			end
		end
	end

	assign m_axis_tvalid = v_s11;
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			m_axis_tdata[WORD_W*k +: WORD_W]     = pl_s11.a_pos[k];
			m_axis_tdata[WORD_W*(3+k) +: WORD_W] = pl_s11.a_step[k];
			m_axis_tdata[WORD_W*(6+k) +: WORD_W] = pl_s11.b_pos[k];
			m_axis_tdata[WORD_W*(9+k) +: WORD_W] = pl_s11.b_step[k];
		end
	end

	// ---------------- Assertions
	`ASSERT_CLK(a_root_bound, rt_v_s[F] && rt_c_s[F].contact |-> ({{F{1'b0}}, rt_root_s[F]} * {{F{1'b0}}, rt_root_s[F]} <= rt_x_s[F]), "root squared exceeds distance squared")
	`ASSERT_CLK(a_norm_bound, dv_v_s[L] && dv_c_s[L].contact && !dv_c_s[L].zero |-> (dv_q_s[L][0] <= QT_W'(ONE)) && (dv_q_s[L][1] <= QT_W'(ONE)) && (dv_q_s[L][2] <= QT_W'(ONE)), "normal component above one")
	`ASSERT_CLK(a_stall_hold, !adv |=> $stable(v_s5) && $stable(v_s9) && $stable(rt_v_s[F]), "pipeline moved during stall")
endmodule
